### design/smtc_pkg.sv
// Shared types, constants and helpers for the sliding-mode tracking controller.
// Holds the microcode ROM, the operand map and the fixed-point arithmetic helpers.
// No dependencies.
package smtc_pkg;

    localparam int WORD_W  = 32;
    localparam int FRAC_W  = 16;
    localparam int GAIN_W  = 31;
    localparam int CFG_AW  = 3;
    localparam int MAG_W   = 48;
    localparam int PROD_W  = 64;
    localparam int STEP_W  = 6;
    localparam int CNT_W   = 6;

    // CORDIC works in Q2.30, z carries two guard bits over the word
    localparam int CORDIC_N  = 24;
    localparam int CORDIC_SH = 30 - FRAC_W;
    localparam int XY_W      = 33;
    localparam int Z_W       = 34;
    localparam int WRAP_N    = 14;
    localparam int DIV_N     = 48;

    localparam logic signed [WORD_W-1:0] WMAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WMIN = 32'sh8000_0000;
    localparam logic [WORD_W-1:0] PI_W     = 32'd205887;
    localparam logic [WORD_W-1:0] TWO_PI_W = 32'd411774;
    localparam logic [WORD_W-1:0] FLOOR_C  = 32'd256;

    localparam logic signed [Z_W-1:0]  PI_Q30      = 34'sd3373259426;
    localparam logic signed [Z_W-1:0]  HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [XY_W-1:0] CORDIC_K    = 33'sd652032874;

    localparam logic [29:0] ATAN_Q30 [CORDIC_N] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    typedef struct packed {
        logic signed [WORD_W-1:0] robot_x;
        logic signed [WORD_W-1:0] robot_y;
        logic signed [WORD_W-1:0] robot_heading;
        logic signed [WORD_W-1:0] robot_speed;
        logic signed [WORD_W-1:0] robot_turn_rate;
        logic signed [WORD_W-1:0] desired_x;
        logic signed [WORD_W-1:0] desired_y;
        logic signed [WORD_W-1:0] desired_heading;
        logic signed [WORD_W-1:0] desired_speed;
        logic signed [WORD_W-1:0] desired_turn_rate;
        logic signed [WORD_W-1:0] desired_accel;
        logic signed [WORD_W-1:0] desired_turn_accel;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] command_speed;
        logic signed [WORD_W-1:0] command_turn_rate;
        logic                     cosine_guard;
    } t_out_item;

    typedef struct packed {
        logic [GAIN_W-1:0] k0;
        logic [GAIN_W-1:0] k1;
        logic [GAIN_W-1:0] k2;
        logic [GAIN_W-1:0] p1;
        logic [GAIN_W-1:0] p2;
        logic [GAIN_W-1:0] q1;
        logic [GAIN_W-1:0] q2;
        logic [GAIN_W-1:0] dt;
    } t_cfg;

    typedef enum logic [CFG_AW-1:0] {
        CFG_K0, CFG_K1, CFG_K2, CFG_P1, CFG_P2, CFG_Q1, CFG_Q2, CFG_DT
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_SWT, OP_WRAP, OP_SC, OP_GETS, OP_DEN, OP_DIV
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE, PH_READ, PH_EXEC, PH_WAIT, PH_WB, PH_OUT
    } t_phase;

    typedef enum logic [1:0] {
        IK_WRAP, IK_SC, IK_DIV
    } t_iter_kind;

    typedef struct packed {
        logic       start;
        t_iter_kind kind;
    } t_iter_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_stat;

    // operand codes: bit 5 clear selects the scratch file
    typedef logic [5:0] t_opnd;

    localparam t_opnd O_T0   = 6'd0;
    localparam t_opnd O_T1   = 6'd1;
    localparam t_opnd O_T2   = 6'd2;
    localparam t_opnd O_CT   = 6'd3;
    localparam t_opnd O_ST   = 6'd4;
    localparam t_opnd O_DX   = 6'd5;
    localparam t_opnd O_DY   = 6'd6;
    localparam t_opnd O_XE   = 6'd7;
    localparam t_opnd O_YE   = 6'd8;
    localparam t_opnd O_TE   = 6'd9;
    localparam t_opnd O_CE   = 6'd10;
    localparam t_opnd O_SE   = 6'd11;
    localparam t_opnd O_XED  = 6'd12;
    localparam t_opnd O_YED  = 6'd13;
    localparam t_opnd O_TED  = 6'd14;
    localparam t_opnd O_S1   = 6'd15;
    localparam t_opnd O_S2   = 6'd16;
    localparam t_opnd O_XR   = 6'd32;
    localparam t_opnd O_YR   = 6'd33;
    localparam t_opnd O_THR  = 6'd34;
    localparam t_opnd O_VR   = 6'd35;
    localparam t_opnd O_WR   = 6'd36;
    localparam t_opnd O_XD   = 6'd37;
    localparam t_opnd O_YD   = 6'd38;
    localparam t_opnd O_THD  = 6'd39;
    localparam t_opnd O_VD   = 6'd40;
    localparam t_opnd O_WD   = 6'd41;
    localparam t_opnd O_VDD  = 6'd42;
    localparam t_opnd O_WDD  = 6'd43;
    localparam t_opnd O_K0   = 6'd44;
    localparam t_opnd O_K1   = 6'd45;
    localparam t_opnd O_K2   = 6'd46;
    localparam t_opnd O_P1   = 6'd47;
    localparam t_opnd O_P2   = 6'd48;
    localparam t_opnd O_Q1   = 6'd49;
    localparam t_opnd O_Q2   = 6'd50;
    localparam t_opnd O_DT   = 6'd51;
    localparam t_opnd O_INTV = 6'd52;
    localparam t_opnd O_INTW = 6'd53;
    localparam t_opnd O_ZERO = 6'd54;

    typedef struct packed {
        t_op   op;
        t_opnd dst;
        t_opnd a;
        t_opnd b;
        logic  last;
    } t_uword;

    function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [WORD_W:0] s);
        if (s[WORD_W] != s[WORD_W-1]) begin
            return s[WORD_W] ? WMIN : WMAX;
        end
        return s[WORD_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] a);
        return a[WORD_W-1] ? (~a + 32'd1) : a;
    endfunction

    function automatic logic signed [WORD_W-1:0] from_mag(input logic [MAG_W-1:0] p,
                                                          input logic neg);
        if (neg) begin
            if (p > 48'h0000_8000_0000) begin
                return WMIN;
            end
            return ~p[WORD_W-1:0] + 32'd1;
        end
        if (p > 48'h0000_7fff_ffff) begin
            return WMAX;
        end
        return p[WORD_W-1:0];
    endfunction

    function automatic logic signed [WORD_W-1:0] ext_val(input t_opnd c, input t_in_item in,
            input t_cfg cfg, input logic signed [WORD_W-1:0] iv,
            input logic signed [WORD_W-1:0] iw);
        case (c)
            O_XR:    return in.robot_x;
            O_YR:    return in.robot_y;
            O_THR:   return in.robot_heading;
            O_VR:    return in.robot_speed;
            O_WR:    return in.robot_turn_rate;
            O_XD:    return in.desired_x;
            O_YD:    return in.desired_y;
            O_THD:   return in.desired_heading;
            O_VD:    return in.desired_speed;
            O_WD:    return in.desired_turn_rate;
            O_VDD:   return in.desired_accel;
            O_WDD:   return in.desired_turn_accel;
            O_K0:    return {1'b0, cfg.k0};
            O_K1:    return {1'b0, cfg.k1};
            O_K2:    return {1'b0, cfg.k2};
            O_P1:    return {1'b0, cfg.p1};
            O_P2:    return {1'b0, cfg.p2};
            O_Q1:    return {1'b0, cfg.q1};
            O_Q2:    return {1'b0, cfg.q2};
            O_DT:    return {1'b0, cfg.dt};
            O_INTV:  return iv;
            O_INTW:  return iw;
            default: return '0;
        endcase
    endfunction

    function automatic t_uword uw(input t_op op, input t_opnd d, input t_opnd a,
                                  input t_opnd b, input logic last);
        t_uword w;
        w.op   = op;
        w.dst  = d;
        w.a    = a;
        w.b    = b;
        w.last = last;
        return w;
    endfunction

    // control program, one word per step
    function automatic t_uword prog_word(input logic [STEP_W-1:0] s);
        unique case (s)
            6'd0:  return uw(OP_WRAP, O_T0,   O_THD,  O_ZERO, 1'b0);
            6'd1:  return uw(OP_SC,   O_CT,   O_T0,   O_ZERO, 1'b0);
            6'd2:  return uw(OP_GETS, O_ST,   O_ZERO, O_ZERO, 1'b0);
            6'd3:  return uw(OP_SUB,  O_DX,   O_XR,   O_XD,   1'b0);
            6'd4:  return uw(OP_SUB,  O_DY,   O_YR,   O_YD,   1'b0);
            6'd5:  return uw(OP_MUL,  O_T0,   O_DX,   O_CT,   1'b0);
            6'd6:  return uw(OP_MUL,  O_T1,   O_DY,   O_ST,   1'b0);
            6'd7:  return uw(OP_ADD,  O_XE,   O_T0,   O_T1,   1'b0);
            6'd8:  return uw(OP_MUL,  O_T0,   O_DY,   O_CT,   1'b0);
            6'd9:  return uw(OP_MUL,  O_T1,   O_DX,   O_ST,   1'b0);
            6'd10: return uw(OP_SUB,  O_YE,   O_T0,   O_T1,   1'b0);
            6'd11: return uw(OP_SUB,  O_T0,   O_THR,  O_THD,  1'b0);
            6'd12: return uw(OP_WRAP, O_TE,   O_T0,   O_ZERO, 1'b0);
            6'd13: return uw(OP_SC,   O_CE,   O_TE,   O_ZERO, 1'b0);
            6'd14: return uw(OP_GETS, O_SE,   O_ZERO, O_ZERO, 1'b0);
            6'd15: return uw(OP_MUL,  O_T0,   O_VR,   O_CE,   1'b0);
            6'd16: return uw(OP_MUL,  O_T1,   O_YE,   O_WD,   1'b0);
            6'd17: return uw(OP_ADD,  O_T0,   O_T0,   O_T1,   1'b0);
            6'd18: return uw(OP_SUB,  O_XED,  O_T0,   O_VD,   1'b0);
            6'd19: return uw(OP_MUL,  O_T0,   O_VR,   O_SE,   1'b0);
            6'd20: return uw(OP_MUL,  O_T1,   O_XE,   O_WD,   1'b0);
            6'd21: return uw(OP_SUB,  O_YED,  O_T0,   O_T1,   1'b0);
            6'd22: return uw(OP_SUB,  O_TED,  O_WR,   O_WD,   1'b0);
            6'd23: return uw(OP_MUL,  O_T0,   O_K1,   O_XE,   1'b0);
            6'd24: return uw(OP_ADD,  O_S1,   O_XED,  O_T0,   1'b0);
            6'd25: return uw(OP_MUL,  O_T0,   O_K2,   O_TE,   1'b0);
            6'd26: return uw(OP_ADD,  O_T0,   O_TED,  O_T0,   1'b0);
            6'd27: return uw(OP_MUL,  O_T1,   O_K0,   O_YE,   1'b0);
            6'd28: return uw(OP_ADD,  O_S2,   O_T0,   O_T1,   1'b0);
            6'd29: return uw(OP_MUL,  O_T0,   O_VR,   O_TED,  1'b0);
            6'd30: return uw(OP_MUL,  O_T1,   O_T0,   O_SE,   1'b0);
            6'd31: return uw(OP_MUL,  O_T0,   O_WDD,  O_YE,   1'b0);
            6'd32: return uw(OP_SUB,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd33: return uw(OP_MUL,  O_T0,   O_WD,   O_YED,  1'b0);
            6'd34: return uw(OP_SUB,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd35: return uw(OP_ADD,  O_T1,   O_T1,   O_VDD,  1'b0);
            6'd36: return uw(OP_MUL,  O_T0,   O_K1,   O_XED,  1'b0);
            6'd37: return uw(OP_SUB,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd38: return uw(OP_MUL,  O_T0,   O_K2,   O_TED,  1'b0);
            6'd39: return uw(OP_SUB,  O_T2,   O_WDD,  O_T0,   1'b0);
            6'd40: return uw(OP_MUL,  O_T0,   O_K0,   O_YED,  1'b0);
            6'd41: return uw(OP_SUB,  O_T2,   O_T2,   O_T0,   1'b0);
            6'd42: return uw(OP_MUL,  O_T0,   O_Q1,   O_S1,   1'b0);
            6'd43: return uw(OP_SUB,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd44: return uw(OP_SWT,  O_T0,   O_S1,   O_P1,   1'b0);
            6'd45: return uw(OP_SUB,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd46: return uw(OP_DEN,  O_T0,   O_CE,   O_ZERO, 1'b0);
            6'd47: return uw(OP_DIV,  O_T1,   O_T1,   O_T0,   1'b0);
            6'd48: return uw(OP_MUL,  O_T0,   O_Q2,   O_S2,   1'b0);
            6'd49: return uw(OP_SUB,  O_T2,   O_T2,   O_T0,   1'b0);
            6'd50: return uw(OP_SWT,  O_T0,   O_S2,   O_P2,   1'b0);
            6'd51: return uw(OP_SUB,  O_T2,   O_T2,   O_T0,   1'b0);
            6'd52: return uw(OP_MUL,  O_T0,   O_DT,   O_T1,   1'b0);
            6'd53: return uw(OP_ADD,  O_INTV, O_INTV, O_T0,   1'b0);
            6'd54: return uw(OP_MUL,  O_T0,   O_DT,   O_T2,   1'b0);
            6'd55: return uw(OP_ADD,  O_INTW, O_INTW, O_T0,   1'b1);
            default: return uw(OP_ADD, O_T0,  O_ZERO, O_ZERO, 1'b1);
        endcase
    endfunction

endpackage

### design/smtc_iter.sv
// Multi-cycle arithmetic unit: angle wrap, CORDIC sine/cosine, restoring divide.
// One iteration per clock. Depends on smtc_pkg.
module smtc_iter (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  smtc_pkg::t_iter_req              i_req,
    input  logic signed [smtc_pkg::WORD_W-1:0] i_a,
    input  logic signed [smtc_pkg::WORD_W-1:0] i_b,
    output smtc_pkg::t_iter_stat             o_stat,
    output logic signed [smtc_pkg::WORD_W-1:0] o_res,
    output logic signed [smtc_pkg::WORD_W-1:0] o_sin
);
    import smtc_pkg::*;

    logic                     r_busy, r_done;
    t_iter_kind               r_kind;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_neg, r_flip;
    logic [WORD_W-1:0]        r_m, r_md;
    logic signed [XY_W-1:0]   r_x, r_y;
    logic signed [Z_W-1:0]    r_z;
    logic [WORD_W:0]          r_rem;
    logic [MAG_W-1:0]         r_q, r_dvd;
    logic signed [WORD_W-1:0] r_res, r_sin;

    // wrap: subtract shifted multiples of 2*pi
    logic [WORD_W-1:0] w_sub, w_m_nxt, w_fold;
    logic signed [WORD_W-1:0] w_wrap;
    // cordic
    logic signed [XY_W-1:0] c_dx, c_dy, c_x_nxt, c_y_nxt, c_xf, c_yf, c_xs, c_ys;
    logic signed [Z_W-1:0]  c_at, c_z_nxt, c_z0;
    // divide
    logic [WORD_W:0]  d_r2, d_rem_nxt;
    logic             d_ge;
    logic [MAG_W-1:0] d_q_nxt;

    always_comb begin
        w_sub   = TWO_PI_W << r_cnt[3:0];
        w_m_nxt = (r_m >= w_sub) ? r_m - w_sub : r_m;
        w_fold  = (r_neg && w_m_nxt != '0) ? TWO_PI_W - w_m_nxt : w_m_nxt;
        w_wrap  = $signed(w_fold) - $signed(PI_W);

        c_dx = r_y >>> r_cnt[4:0];
        c_dy = r_x >>> r_cnt[4:0];
        c_at = $signed({4'b0, ATAN_Q30[r_cnt[4:0]]});
        if (r_z >= 0) begin
            c_x_nxt = r_x - c_dx;
            c_y_nxt = r_y + c_dy;
            c_z_nxt = r_z - c_at;
        end else begin
            c_x_nxt = r_x + c_dx;
            c_y_nxt = r_y - c_dy;
            c_z_nxt = r_z + c_at;
        end
        c_xf = r_flip ? -c_x_nxt : c_x_nxt;
        c_yf = r_flip ? -c_y_nxt : c_y_nxt;
        c_xs = c_xf >>> CORDIC_SH;
        c_ys = c_yf >>> CORDIC_SH;
        c_z0 = $signed({i_a[Z_W-CORDIC_SH-1:0], {CORDIC_SH{1'b0}}});

        d_r2      = {r_rem[WORD_W-1:0], r_dvd[MAG_W-1]};
        d_ge      = d_r2 >= {1'b0, r_md};
        d_rem_nxt = d_ge ? d_r2 - {1'b0, r_md} : d_r2;
        d_q_nxt   = {r_q[MAG_W-2:0], d_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_kind <= IK_WRAP;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_kind <= i_req.kind;
                unique case (i_req.kind)
                    IK_WRAP: r_cnt <= CNT_W'(WRAP_N - 1);
                    IK_SC:   r_cnt <= '0;
                    default: r_cnt <= CNT_W'(DIV_N - 1);
                endcase
            end else if (r_busy) begin
                if ((r_kind == IK_SC && r_cnt == CNT_W'(CORDIC_N - 1)) ||
                    (r_kind != IK_SC && r_cnt == '0)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (r_kind == IK_SC) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        logic signed [Z_W-1:0] v;
        v = $signed({{(Z_W-WORD_W){i_a[WORD_W-1]}}, i_a}) + $signed({2'b0, PI_W});
        if (i_req.start) begin
            unique case (i_req.kind)
                IK_WRAP: begin
                    r_neg <= v[Z_W-1];
                    r_m   <= v[Z_W-1] ? WORD_W'(-v) : v[WORD_W-1:0];
                end
                IK_SC: begin
                    r_x <= CORDIC_K;
                    r_y <= '0;
                    if (c_z0 > HALF_PI_Q30) begin
                        r_z    <= c_z0 - PI_Q30;
                        r_flip <= 1'b1;
                    end else if (c_z0 < -HALF_PI_Q30) begin
                        r_z    <= c_z0 + PI_Q30;
                        r_flip <= 1'b1;
                    end else begin
                        r_z    <= c_z0;
                        r_flip <= 1'b0;
                    end
                end
                default: begin
                    r_neg <= i_a[WORD_W-1] ^ i_b[WORD_W-1];
                    r_md  <= mag32(i_b);
                    r_dvd <= {mag32(i_a), {FRAC_W{1'b0}}};
                    r_rem <= '0;
                    r_q   <= '0;
                end
            endcase
        end else if (r_busy) begin
            unique case (r_kind)
                IK_WRAP: begin
                    r_m <= w_m_nxt;
                    if (r_cnt == '0) begin
                        r_res <= w_wrap;
                    end
                end
                IK_SC: begin
                    r_x <= c_x_nxt;
                    r_y <= c_y_nxt;
                    r_z <= c_z_nxt;
                    if (r_cnt == CNT_W'(CORDIC_N - 1)) begin
                        r_res <= c_xs[WORD_W-1:0];
                        r_sin <= c_ys[WORD_W-1:0];
                    end
                end
                default: begin
                    r_rem <= d_rem_nxt;
                    r_q   <= d_q_nxt;
                    r_dvd <= {r_dvd[MAG_W-2:0], 1'b0};
                    if (r_cnt == '0) begin
                        r_res <= from_mag(d_q_nxt, r_neg);
                    end
                end
            endcase
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_res;
    assign o_sin       = r_sin;

endmodule

### design/sliding_mode_tracking_controller.sv
// Sliding-mode trajectory tracking controller for a unicycle robot, Q16.16.
// A 56-step microcode program in smtc_pkg drives a scratch file, one 32x32 multiplier
// and the smtc_iter unit. A plain step passes through read, execute and write-back; a
// step on the iterative unit (angle wrap, sine/cosine, divide) also waits between
// execute and write-back until the unit reports done. After the last step the result
// is loaded into the output register, which an output stall can hold off.
// Items are processed one at a time; a finished beat waits in the output register while
// the next input beat is taken. Depends on smtc_pkg and smtc_iter.
module sliding_mode_tracking_controller (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  smtc_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output smtc_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_we,
    input  logic [smtc_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [smtc_pkg::GAIN_W-1:0]  i_cfg_data
);
    import smtc_pkg::*;

    t_phase                   r_phase, n_phase;
    logic [STEP_W-1:0]        r_step;
    t_cfg                     r_cfg;
    t_in_item                 r_in;
    logic signed [WORD_W-1:0] r_rf [32];
    logic signed [WORD_W-1:0] r_a, r_b, r_res, r_intv, r_intw;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg, r_guard, r_out_valid;
    t_out_item                r_out;

    t_uword                   w_uw;
    t_iter_req                w_req;
    t_iter_stat               w_stat;
    logic signed [WORD_W-1:0] w_it_res, w_it_sin, w_wb, w_alu, w_swt;
    logic [PROD_W-1:0]        w_prod;
    logic                     w_in_acc, w_out_load, w_long;

    assign w_uw     = prog_word(r_step);
    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_long   = (w_uw.op == OP_WRAP) || (w_uw.op == OP_SC) || (w_uw.op == OP_DIV);

    smtc_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_stat  (w_stat),
        .o_res   (w_it_res),
        .o_sin   (w_it_sin)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        o_in_ready = 1'b0;
        w_out_load = 1'b0;
        w_req.start = 1'b0;
        w_req.kind  = IK_WRAP;
        unique case (r_phase)
            PH_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) n_phase = PH_READ;
            end
            PH_READ: n_phase = PH_EXEC;
            PH_EXEC: begin
                if (w_long) begin
                    w_req.start = 1'b1;
                    unique case (w_uw.op)
                        OP_WRAP: w_req.kind = IK_WRAP;
                        OP_SC:   w_req.kind = IK_SC;
                        default: w_req.kind = IK_DIV;
                    endcase
                    n_phase = PH_WAIT;
                end else begin
                    n_phase = PH_WB;
                end
            end
            PH_WAIT: if (w_stat.done) n_phase = PH_WB;
            PH_WB:   n_phase = w_uw.last ? PH_OUT : PH_READ;
            PH_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load = 1'b1;
                    n_phase    = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (w_in_acc) begin
            r_step <= '0;
        end else if (r_phase == PH_WB && !w_uw.last) begin
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k0 <= 31'd65536;
            r_cfg.k1 <= 31'd65536;
            r_cfg.k2 <= 31'd65536;
            r_cfg.p1 <= '0;
            r_cfg.p2 <= '0;
            r_cfg.q1 <= 31'd65536;
            r_cfg.q2 <= 31'd65536;
            r_cfg.dt <= 31'd655;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_K0:  r_cfg.k0 <= i_cfg_data;
                CFG_K1:  r_cfg.k1 <= i_cfg_data;
                CFG_K2:  r_cfg.k2 <= i_cfg_data;
                CFG_P1:  r_cfg.p1 <= i_cfg_data;
                CFG_P2:  r_cfg.p2 <= i_cfg_data;
                CFG_Q1:  r_cfg.q1 <= i_cfg_data;
                CFG_Q2:  r_cfg.q2 <= i_cfg_data;
                default: r_cfg.dt <= i_cfg_data;
            endcase
        end
    end

    // execute-phase arithmetic on the registered operands
    always_comb begin
        w_prod = mag32(r_a) * mag32(r_b);
        if (r_a > 0)      w_swt = r_b;
        else if (r_a < 0) w_swt = -r_b;
        else              w_swt = '0;
        case (w_uw.op)
            OP_SUB:  w_alu = sat_sum({r_a[WORD_W-1], r_a} - {r_b[WORD_W-1], r_b});
            OP_SWT:  w_alu = w_swt;
            OP_GETS: w_alu = w_it_sin;
            OP_DEN: begin
                if (mag32(r_a) < FLOOR_C) w_alu = r_a[WORD_W-1] ? -FLOOR_C : FLOOR_C;
                else                      w_alu = r_a;
            end
            default: w_alu = sat_sum({r_a[WORD_W-1], r_a} + {r_b[WORD_W-1], r_b});
        endcase
        w_wb = (w_uw.op == OP_MUL) ? from_mag(r_mag, r_neg) : r_res;
    end

    // scratch file and operand fetch
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in_data;
        end
        if (r_phase == PH_READ) begin
            r_a <= w_uw.a[5] ? ext_val(w_uw.a, r_in, r_cfg, r_intv, r_intw)
                             : r_rf[w_uw.a[4:0]];
            r_b <= w_uw.b[5] ? ext_val(w_uw.b, r_in, r_cfg, r_intv, r_intw)
                             : r_rf[w_uw.b[4:0]];
        end
        if (r_phase == PH_EXEC) begin
            r_res <= w_alu;
            r_mag <= w_prod[PROD_W-1:FRAC_W];
            r_neg <= r_a[WORD_W-1] ^ r_b[WORD_W-1];
        end
        if (r_phase == PH_WAIT && w_stat.done) begin
            r_res <= w_it_res;
        end
        if (r_phase == PH_WB && !w_uw.dst[5]) begin
            r_rf[w_uw.dst[4:0]] <= w_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intv  <= '0;
            r_intw  <= '0;
            r_guard <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_guard <= 1'b0;
            end else if (r_phase == PH_EXEC && w_uw.op == OP_DEN) begin
                r_guard <= mag32(r_a) < FLOOR_C;
            end
            if (r_phase == PH_WB && w_uw.dst == O_INTV) r_intv <= w_wb;
            if (r_phase == PH_WB && w_uw.dst == O_INTW) r_intw <= w_wb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.command_speed     <= r_intv;
            r_out.command_turn_rate <= r_intw;
            r_out.cosine_guard      <= r_guard;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### design/smtc_checker.sv
// Port-level checks for sliding_mode_tracking_controller, attached by bind.
// Depends on smtc_pkg.
module smtc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input smtc_pkg::t_out_item         o_out_data
);

    // output beat held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // one item at a time: ready drops right after an input beat
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while item in flight");

    // result cannot appear right after acceptance
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind sliding_mode_tracking_controller smtc_checker u_smtc_checker (.*);
